// ===== src/btb_pkg.sv =====
// btb_pkg: types, widths and reset values for box_transform_bounds
// no dependencies; imported by the top level, its checker and the bench
package btb_pkg;

   localparam int CW = 32;            // coordinate width
   localparam int EW = 31;            // extent width
   localparam int MW = 32;            // matrix coefficient width
   localparam int PW = 2 * MW - 16;   // product after the Q16 shift
   localparam int SW = PW + 2;        // sum of four terms
   localparam int HW = 48;            // homogeneous coordinate width
   localparam int DW = HW - 1;        // magnitude of a homogeneous value
   localparam int NW = 64;            // scaled numerator magnitude
   localparam int QW = CW + 1;        // quotient bits kept
   localparam int XW = DW + QW;       // width of the shifted divisor
   localparam int REGS = 8;
   localparam int IW = 4;             // csr index width, sees writes above the list
   localparam int RW = 64;

   localparam logic signed [HW-1:0] H_MAX = {1'b0, {(HW-1){1'b1}}};
   localparam logic signed [HW-1:0] H_MIN = {1'b1, {(HW-2){1'b0}}, 1'b1};
   localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

   // identity matrix in Q16.16
   localparam logic [RW-1:0] MATRIX_RESET [REGS] = '{
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000};

   typedef struct packed {
      logic signed [CW-1:0] center_x;
      logic signed [CW-1:0] center_y;
      logic signed [CW-1:0] center_z;
      logic [EW-1:0]        extent_x;
      logic [EW-1:0]        extent_y;
      logic [EW-1:0]        extent_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] out_min_x;
      logic signed [CW-1:0] out_min_y;
      logic signed [CW-1:0] out_min_z;
      logic signed [CW-1:0] out_max_x;
      logic signed [CW-1:0] out_max_y;
      logic signed [CW-1:0] out_max_z;
      logic                 divide_error;
   } rsp_type;

   // one stage of the three-lane restoring divider
   typedef struct packed {
      logic                  valid;
      logic                  first;
      logic                  last;
      logic                  dzero;
      logic [2:0]            neg;
      logic [2:0]            ovf;
      logic [2:0]            nzero;
      logic [2:0]            npos;
      logic [DW-1:0]         den;
      logic [2:0][NW-1:0]    rem;
      logic [2:0][QW-1:0]    quo;
   } div_type;

endpackage

// ===== src/box_transform_bounds.sv =====
// box_transform_bounds: projected min/max bounds of a box under a 4x4 matrix
// depends on btb_pkg
//
// A box transaction is taken, then its eight corners go one per cycle through
// a pipeline: corner add, 12 multipliers, row sums, a divide-setup stage, 33
// restoring divide stages (three lanes, one quotient bit each), a select
// stage and a min/max stage. The single corner path takes a new box when idle
// or while the last corner of the previous box is issued. When the result
// register is stalled the whole pipeline holds.
module box_transform_bounds import btb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data,
   input  logic           csr_we,
   input  logic [IW-1:0]  csr_index,
   input  logic [RW-1:0]  csr_wdata
);

   logic [RW-1:0] matrix_ff [REGS];
   logic signed [MW-1:0] coef [4][4];
   logic adv, accept;

   // matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REGS; i++) matrix_ff[i] <= MATRIX_RESET[i];
      end else if (csr_we && csr_index < IW'(REGS)) begin
         matrix_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            coef[r][c] = matrix_ff[2*r + (c >> 1)][MW*(c & 1) +: MW];
   end

   // output register gates the whole pipeline
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   assign adv = !rsp_valid_ff || !rsp_stall;

   // corner sequencer
   logic busy_ff;
   logic [2:0] cnt_ff;
   req_type box_ff;
   assign req_stall = !adv || (busy_ff && cnt_ff != 3'd7);
   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (adv) begin
         if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            busy_ff <= (cnt_ff == 3'd7) ? accept : 1'b1;
         end else begin
            busy_ff <= accept;
            cnt_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) box_ff <= req_data;
   end

   // stage 0: corner coordinates, saturated
   logic s0_valid_ff, s0_first_ff, s0_last_ff;
   logic [2:0][CW-1:0] s0_p_ff, s0_p_in;
   logic signed [CW-1:0] ctr [3];
   logic [EW-1:0] ext [3];

   always_comb begin
      logic signed [CW:0] sum;
      ctr[0] = box_ff.center_x; ctr[1] = box_ff.center_y; ctr[2] = box_ff.center_z;
      ext[0] = box_ff.extent_x; ext[1] = box_ff.extent_y; ext[2] = box_ff.extent_z;
      sum = '0;
      for (int a = 0; a < 3; a++) begin
         if (cnt_ff[a])
            sum = {ctr[a][CW-1], ctr[a]} + $signed({2'b00, ext[a]});
         else
            sum = {ctr[a][CW-1], ctr[a]} - $signed({2'b00, ext[a]});
         if (sum > $signed({C_MAX[CW-1], C_MAX}))      s0_p_in[a] = C_MAX;
         else if (sum < $signed({C_MIN[CW-1], C_MIN})) s0_p_in[a] = C_MIN;
         else                                          s0_p_in[a] = sum[CW-1:0];
      end
   end

   // stage 1: products, floor shift by 16
   logic s1_valid_ff, s1_first_ff, s1_last_ff;
   logic [3:0][2:0][PW-1:0] s1_prod_ff, s1_prod_in;

   always_comb begin
      logic signed [2*MW-1:0] full;
      full = '0;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 3; c++) begin
            full = coef[r][c] * $signed(s0_p_ff[c]);
            s1_prod_in[r][c] = full[2*MW-1:16];
         end
   end

   // stage 2: row sums, saturated to the homogeneous range
   logic s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [3:0][HW-1:0] s2_h_ff, s2_h_in;

   always_comb begin
      logic signed [SW-1:0] s;
      s = '0;
      for (int r = 0; r < 4; r++) begin
         s = SW'($signed(coef[r][3]));
         for (int c = 0; c < 3; c++)
            s = s + SW'($signed(s1_prod_ff[r][c]));
         if (s > SW'(H_MAX))      s2_h_in[r] = H_MAX;
         else if (s < SW'(H_MIN)) s2_h_in[r] = H_MIN;
         else                     s2_h_in[r] = s[HW-1:0];
      end
   end

   // divide setup and restoring steps
   div_type div_ff [QW+1];
   div_type div_in [QW+1];

   always_comb begin
      logic [HW-1:0] mag;
      logic [HW-1:0] dmag;
      logic [XW-1:0] shd;
      div_in[0] = '0;
      div_in[0].valid = s2_valid_ff;
      div_in[0].first = s2_first_ff;
      div_in[0].last = s2_last_ff;
      dmag = s2_h_ff[3][HW-1] ? -s2_h_ff[3] : s2_h_ff[3];
      div_in[0].den = dmag[DW-1:0];
      div_in[0].dzero = (s2_h_ff[3] == '0);
      for (int a = 0; a < 3; a++) begin
         mag = s2_h_ff[a][HW-1] ? -s2_h_ff[a] : s2_h_ff[a];
         div_in[0].rem[a] = NW'({mag[DW-1:0], 16'b0});
         div_in[0].neg[a] = s2_h_ff[a][HW-1] ^ s2_h_ff[3][HW-1];
         div_in[0].nzero[a] = (s2_h_ff[a] == '0);
         div_in[0].npos[a] = !s2_h_ff[a][HW-1] && (s2_h_ff[a] != '0);
         div_in[0].ovf[a] = XW'(div_in[0].rem[a]) >= {dmag[DW-1:0], {QW{1'b0}}};
      end
      shd = '0;
      for (int j = 0; j < QW; j++) begin
         div_in[j+1] = div_ff[j];
         shd = XW'(div_ff[j].den) << (QW - 1 - j);
         for (int a = 0; a < 3; a++) begin
            if (XW'(div_ff[j].rem[a]) >= shd) begin
               div_in[j+1].rem[a] = div_ff[j].rem[a] - shd[NW-1:0];
               div_in[j+1].quo[a][QW-1-j] = 1'b1;
            end
         end
      end
   end

   // select stage: sign, saturation and zero-w cases
   logic fin_valid_ff, fin_first_ff, fin_last_ff, fin_err_ff;
   logic [2:0][CW-1:0] fin_v_ff, fin_v_in;

   always_comb begin
      div_type d;
      d = div_ff[QW];
      for (int a = 0; a < 3; a++) begin
         if (d.dzero)
            fin_v_in[a] = d.npos[a] ? C_MAX : (d.nzero[a] ? '0 : C_MIN);
         else if (!d.neg[a])
            fin_v_in[a] = (d.ovf[a] || d.quo[a][QW-1:QW-2] != 2'b00) ? C_MAX
                                                                : d.quo[a][CW-1:0];
         else
            fin_v_in[a] = (d.ovf[a] || d.quo[a] > {2'b01, {(CW-1){1'b0}}}) ? C_MIN
                                                                : -d.quo[a][CW-1:0];
      end
   end

   // min/max over the eight corners
   logic signed [CW-1:0] acc_min_ff [3], acc_max_ff [3];
   logic acc_err_ff;
   logic signed [CW-1:0] nmin [3], nmax [3];
   logic nerr;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (fin_first_ff || $signed(fin_v_ff[a]) < acc_min_ff[a]) nmin[a] = fin_v_ff[a];
         else nmin[a] = acc_min_ff[a];
         if (fin_first_ff || $signed(fin_v_ff[a]) > acc_max_ff[a]) nmax[a] = fin_v_ff[a];
         else nmax[a] = acc_max_ff[a];
      end
      nerr = fin_err_ff || (!fin_first_ff && acc_err_ff);
      rsp_valid_in = fin_valid_ff && fin_last_ff;
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j <= QW; j++) div_ff[j] <= '0;
      end else if (adv) begin
         s0_valid_ff <= busy_ff;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         for (int j = 0; j <= QW; j++) div_ff[j] <= div_in[j];
         fin_valid_ff <= div_ff[QW].valid;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_first_ff <= (cnt_ff == 3'd0);
         s0_last_ff <= (cnt_ff == 3'd7);
         s0_p_ff <= s0_p_in;
         s1_first_ff <= s0_first_ff;
         s1_last_ff <= s0_last_ff;
         s1_prod_ff <= s1_prod_in;
         s2_first_ff <= s1_first_ff;
         s2_last_ff <= s1_last_ff;
         s2_h_ff <= s2_h_in;
         fin_first_ff <= div_ff[QW].first;
         fin_last_ff <= div_ff[QW].last;
         fin_err_ff <= div_ff[QW].dzero;
         fin_v_ff <= fin_v_in;
         if (fin_valid_ff) begin
            for (int a = 0; a < 3; a++) begin
               acc_min_ff[a] <= nmin[a];
               acc_max_ff[a] <= nmax[a];
            end
            acc_err_ff <= nerr;
         end
         if (rsp_valid_in) begin
            rsp_data_ff.out_min_x <= nmin[0];
            rsp_data_ff.out_min_y <= nmin[1];
            rsp_data_ff.out_min_z <= nmin[2];
            rsp_data_ff.out_max_x <= nmax[0];
            rsp_data_ff.out_max_y <= nmax[1];
            rsp_data_ff.out_max_z <= nmax[2];
            rsp_data_ff.divide_error <= nerr;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ===== src/btb_checker.sv =====
// btb_checker: port-level assertions for box_transform_bounds
// depends on btb_pkg; bound to the top level below
module btb_checker import btb_pkg::*; (
   input logic           clock,
   input logic           reset,
   input logic           req_valid,
   input logic           req_stall,
   input req_type        req_data,
   input logic           rsp_valid,
   input logic           rsp_stall,
   input rsp_type        rsp_data,
   input logic           csr_we,
   input logic [IW-1:0]  csr_index,
   input logic [RW-1:0]  csr_wdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a box occupies the corner path, so no transaction right after another
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted twice in a row");

   // a stalled result freezes the input side too
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while pipeline held");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind box_transform_bounds btb_checker u_btb_checker (.*);

// ===== tb/sv/box_transform_bounds_tb.sv =====
// box_transform_bounds_tb: self-checking bench for the projected box bounds block
// depends on btb_pkg and box_transform_bounds; predicts each result in Q16.16
`timescale 1ns / 100ps

module box_transform_bounds_tb;
   import btb_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 80;

   // register indexes
   typedef enum logic [IW-1:0] {
      R0C01 = 4'd0, R0C23 = 4'd1, R1C01 = 4'd2, R1C23 = 4'd3,
      R2C01 = 4'd4, R2C23 = 4'd5, R3C01 = 4'd6, R3C23 = 4'd7,
      BAD_INDEX = 4'd9
   } matrix_index_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [IW-1:0] csr_index = '0;
   logic [RW-1:0] csr_wdata = '0;

   logic [63:0] matrix_model [REGS];
   rsp_type bounds_queue [$];
   int mismatch_count = 0;
   int box_count = 0;
   int bounds_count = 0;
   int error_count = 0;
   longint cycle_count = 0;
   bit stall_stretch = 1'b0;

   box_transform_bounds dut (.*);

   // clock and run limit
   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("box_transform_bounds verification failed");
         $finish;
      end
   end

   // fixed point helpers
   function automatic longint sat_coord(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint coef_of(int r, int c);
      logic [63:0] reg_val;
      logic signed [31:0] half;
      reg_val = matrix_model[r * 2 + c / 2];
      half = (c % 2) ? reg_val[63:32] : reg_val[31:0];
      return longint'(half);
   endfunction

   // projected bounds of one box under the current matrix
   function automatic rsp_type project_bounds(req_type box);
      longint ctr [3];
      longint ext [3];
      longint lo [3];
      longint hi [3];
      longint p [4];
      longint h [4];
      longint s;
      longint v;
      rsp_type res;
      bit err;
      err = 1'b0;
      ctr[0] = box.center_x; ctr[1] = box.center_y; ctr[2] = box.center_z;
      ext[0] = longint'({1'b0, box.extent_x});
      ext[1] = longint'({1'b0, box.extent_y});
      ext[2] = longint'({1'b0, box.extent_z});
      for (int i = 0; i < 8; i++) begin
         for (int a = 0; a < 3; a++)
            p[a] = sat_coord(((i >> a) & 1) ? ctr[a] + ext[a] : ctr[a] - ext[a]);
         p[3] = 65536;
         for (int r = 0; r < 4; r++) begin
            s = 0;
            for (int c = 0; c < 4; c++)
               s += (coef_of(r, c) * p[c]) >>> 16;
            if (s > 64'sd140737488355327) s = 64'sd140737488355327;
            if (s < -64'sd140737488355327) s = -64'sd140737488355327;
            h[r] = s;
         end
         for (int a = 0; a < 3; a++) begin
            if (h[3] == 0) begin
               err = 1'b1;
               v = (h[a] > 0) ? 64'sd2147483647 : (h[a] < 0) ? -64'sd2147483648 : 0;
            end else begin
               v = sat_coord((h[a] * 65536) / h[3]);
            end
            if (i == 0 || v < lo[a]) lo[a] = v;
            if (i == 0 || v > hi[a]) hi[a] = v;
         end
      end
      res.out_min_x = lo[0][31:0]; res.out_min_y = lo[1][31:0];
      res.out_min_z = lo[2][31:0];
      res.out_max_x = hi[0][31:0]; res.out_max_y = hi[1][31:0];
      res.out_max_z = hi[2][31:0];
      res.divide_error = err;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("mismatch %s at cycle %0d: got %h want %h", what, cycle_count, got, want);
   endtask

   // result side: random stall, compare each transaction with the oldest prediction
   initial begin
      int wait_cycles;
      rsp_type want;
      forever begin
         @(negedge clock);
         if (!stall_stretch && $urandom_range(0, 3) == 0) begin
            wait_cycles = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (bounds_queue.size() == 0) begin
            report_mismatch("unexpected result", '0, '0);
         end else begin
            want = bounds_queue.pop_front();
            bounds_count++;
            if (want.divide_error) error_count++;
            if (rsp_data.out_min_x !== want.out_min_x)
               report_mismatch("out_min_x", rsp_data.out_min_x, want.out_min_x);
            if (rsp_data.out_min_y !== want.out_min_y)
               report_mismatch("out_min_y", rsp_data.out_min_y, want.out_min_y);
            if (rsp_data.out_min_z !== want.out_min_z)
               report_mismatch("out_min_z", rsp_data.out_min_z, want.out_min_z);
            if (rsp_data.out_max_x !== want.out_max_x)
               report_mismatch("out_max_x", rsp_data.out_max_x, want.out_max_x);
            if (rsp_data.out_max_y !== want.out_max_y)
               report_mismatch("out_max_y", rsp_data.out_max_y, want.out_max_y);
            if (rsp_data.out_max_z !== want.out_max_z)
               report_mismatch("out_max_z", rsp_data.out_max_z, want.out_max_z);
            if (rsp_data.divide_error !== want.divide_error)
               report_mismatch("divide_error", 32'(rsp_data.divide_error),
                               32'(want.divide_error));
         end
      end
   end

   // send one box transaction after a random gap; valid stays high into the next one
   task automatic send_box(req_type box, bit no_gap = 1'b0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= box;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bounds_queue.push_back(project_bounds(box));
      box_count++;
      @(negedge clock);
   endtask

   task automatic write_matrix(logic [IW-1:0] idx, logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (idx < REGS) matrix_model[idx[2:0]] = val;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (bounds_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [63:0] pack_pair(logic [31:0] c0, logic [31:0] c1);
      return {c1, c0};
   endfunction

   function automatic req_type rand_box(int mag);
      req_type b;
      b.center_x = $urandom; b.center_y = $urandom; b.center_z = $urandom;
      b.extent_x = EW'($urandom); b.extent_y = EW'($urandom); b.extent_z = EW'($urandom);
      if (mag == 0) begin
         // moderate boxes, each corner within 160 units of the origin
         b.center_x = $signed(b.center_x) >>> 8; b.center_y = $signed(b.center_y) >>> 8;
         b.center_z = $signed(b.center_z) >>> 8;
         b.extent_x = b.extent_x >> 10; b.extent_y = b.extent_y >> 10;
         b.extent_z = b.extent_z >> 10;
      end
      return b;
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'h0001_0000;
         2: return 32'hFFFF_0000;
         3: return $urandom;
         default: return $signed($urandom) >>> $urandom_range(10, 15);
      endcase
   endfunction

   // extremes and special cases under the identity matrix
   task automatic test_extremes();
      req_type b;
      b = '0;
      send_box(b);
      b.center_x = 32'h7FFF_FFFF; b.center_y = 32'h8000_0000; b.center_z = 32'h0001_0000;
      b.extent_x = 31'h7FFF_FFFF; b.extent_y = 31'h7FFF_FFFF; b.extent_z = 31'h7FFF_FFFF;
      send_box(b);
      b.center_x = 32'h8000_0000; b.center_y = 32'h7FFF_FFFF; b.center_z = 32'hFFFF_FFFF;
      b.extent_x = '0; b.extent_y = 31'h1; b.extent_z = 31'h4000_0000;
      send_box(b);
      b.center_x = 32'hFFFF_8000; b.center_y = 32'h0000_8000; b.center_z = 32'h1234_5678;
      b.extent_x = 31'h0000_0001; b.extent_y = 31'h5555_5555; b.extent_z = 31'h2AAA_AAAA;
      send_box(b);
   endtask

   // zero w, perspective, saturation and out-of-range index matrices
   task automatic test_matrices();
      req_type b;
      wait_idle();
      // w row all zero: every corner divides by zero
      write_matrix(R3C01, 64'd0);
      write_matrix(R3C23, 64'd0);
      b = '0; send_box(b);
      b.center_x = 32'h0002_0000; b.extent_x = 31'h0001_0000;
      b.center_y = 32'hFFFE_0000; send_box(b);
      b.extent_y = 31'h0003_0000; send_box(b);
      wait_idle();
      // perspective: w = z
      write_matrix(R3C23, pack_pair(32'h0001_0000, 32'h0));
      b = '0; b.center_x = 32'h0004_0000; b.center_z = 32'h0002_0000;
      b.extent_z = 31'h0002_0000; b.extent_x = 31'h0001_8000;
      send_box(b);
      b.center_z = 32'hFFFF_0000; b.extent_z = 31'h0000_0001; send_box(b);
      wait_idle();
      // large coefficients that saturate the homogeneous sums
      write_matrix(R0C01, pack_pair(32'h7FFF_FFFF, 32'h8000_0000));
      write_matrix(R0C23, pack_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      write_matrix(R1C01, pack_pair(32'h8000_0000, 32'h8000_0000));
      write_matrix(R1C23, pack_pair(32'h8000_0000, 32'h8000_0000));
      write_matrix(R2C01, 64'hFFFF_FFFF_FFFF_FFFF);
      write_matrix(R2C23, pack_pair(32'hFFFF_FFFF, 32'h0));
      write_matrix(R3C01, pack_pair(32'h0, 32'h0));
      write_matrix(R3C23, pack_pair(32'h0, 32'h0000_0001));
      b.center_x = 32'h7FFF_FFFF; b.center_y = 32'h8000_0000; b.center_z = 32'h7FFF_FFFF;
      b.extent_x = 31'h7FFF_FFFF; b.extent_y = 31'h1; b.extent_z = 31'h0;
      send_box(b);
      b = '0; send_box(b);
      wait_idle();
      // an index beyond the matrix changes nothing
      write_matrix(BAD_INDEX, 64'hDEAD_BEEF_0000_0000);
      write_matrix(R3C23, 64'hFFFF_FFFF_FFFF_FFFF);
      b = rand_box(0); send_box(b);
      b = rand_box(1); send_box(b);
      wait_idle();
      for (int i = 0; i < REGS; i++) write_matrix(i[IW-1:0], MATRIX_RESET[i]);
      send_box(rand_box(0));
   endtask

   // random boxes under random matrices, with back to back bursts
   task automatic test_random(int total);
      int phase_len;
      int sent;
      sent = 0;
      while (sent < total) begin
         wait_idle();
         for (int i = 0; i < REGS; i++) begin
            if ($urandom_range(0, 1))
               write_matrix(i[IW-1:0], pack_pair(rand_coef(), rand_coef()));
            else
               write_matrix(i[IW-1:0], MATRIX_RESET[i]);
         end
         if ($urandom_range(0, 3) == 0)
            write_matrix(R3C23, pack_pair(rand_coef(), 32'h0001_0000));
         phase_len = $urandom_range(50, 150);
         stall_stretch = $urandom_range(0, 3) == 0;
         for (int k = 0; k < phase_len && sent < total; k++) begin
            send_box(rand_box($urandom_range(0, 3) == 0), stall_stretch);
            sent++;
         end
         stall_stretch = 1'b0;
      end
   endtask

   initial begin
      for (int i = 0; i < REGS; i++) matrix_model[i] = MATRIX_RESET[i];
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_matrices();
      test_random(1730);
      wait_idle();
      $display("sent %0d boxes, checked %0d bounds, %0d with a zero w corner",
               box_count, bounds_count, error_count);
      if (mismatch_count == 0 && bounds_queue.size() == 0) begin
         $display("box_transform_bounds verification clean");
      end else begin
         $display("box_transform_bounds verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/btb_pkg.sv
src/box_transform_bounds.sv
src/btb_checker.sv
tb/sv/box_transform_bounds_tb.sv
